// ===== rtl/core/shl_pkg.sv =====
`default_nettype none

package shl_pkg;

    localparam int DATA_W         = 32;
    localparam int STATUS_W       = 4;
    localparam int HISTORY_LENGTH = 2;
    localparam int FILL_W         = $clog2(HISTORY_LENGTH + 1);

    // shift-add multiply and restoring divide step counts
    localparam int MUL_STEPS = DATA_W;
    localparam int DIV_STEPS = 2 * DATA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // mode register codes; code 3 is unused and behaves as none
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_HOLD   = 2'd1;
    localparam logic [1:0] MODE_EXTRAP = 2'd2;

    typedef enum logic [1:0] {
        KIND_FRESH  = 2'd0,
        KIND_HELD   = 2'd1,
        KIND_EXTRAP = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC
    } t_state;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } t_md_state;

endpackage

`default_nettype wire

// ===== rtl/core/shl_if.sv =====
`default_nettype none

interface shl_in_if;
    logic               valid;
    logic               ready;
    logic        [31:0] now_time;
    logic        [31:0] seq_number;
    logic signed [31:0] sample_value;
    logic        [31:0] sample_rms;
    logic        [3:0]  sample_status;

    modport source (
        output valid, now_time, seq_number, sample_value, sample_rms, sample_status,
        input  ready
    );
    modport sink (
        input  valid, now_time, seq_number, sample_value, sample_rms, sample_status,
        output ready
    );
endinterface

interface shl_out_if;
    logic               valid;
    logic               ready;
    logic        [31:0] valid_time;
    logic signed [31:0] out_value;
    logic        [31:0] out_rms;
    logic        [3:0]  out_status;
    logic        [1:0]  result_kind;

    modport source (
        output valid, valid_time, out_value, out_rms, out_status, result_kind,
        input  ready
    );
    modport sink (
        input  valid, valid_time, out_value, out_rms, out_status, result_kind,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/shl_muldiv.sv =====
`default_nettype none

// Unsigned 32x32 multiply then 64/32 divide, one bit per cycle,
// both phases on one shared 33-bit add/subtract unit.
module shl_muldiv
    import shl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DATA_W-1:0]     i_mcand,
    input  wire logic [DATA_W-1:0]     i_mplier,
    input  wire logic [DATA_W-1:0]     i_divisor,
    output logic                       o_done,
    output logic [2*DATA_W-1:0]        o_quot
);

    t_md_state          r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DATA_W-1:0]  r_hi, n_hi;
    logic [DATA_W-1:0]  r_lo, n_lo;
    logic [DATA_W-1:0]  r_rem, n_rem;
    logic [DATA_W-1:0]  r_b, n_b;
    logic [DATA_W-1:0]  r_d, n_d;

    // shared adder
    logic [DATA_W:0]    alu_a, alu_b;
    logic               alu_sub;
    logic [DATA_W+1:0]  alu_res;

    assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + {{(DATA_W+1){1'b0}}, alu_sub};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_rem <= n_rem;
        r_b   <= n_b;
        r_d   <= n_d;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_rem   = r_rem;
        n_b     = r_b;
        n_d     = r_d;
        alu_a   = {1'b0, r_hi};
        alu_b   = '0;
        alu_sub = 1'b0;
        o_done  = 1'b0;
        unique case (r_state)
            MD_IDLE: begin
                if (i_start) begin
                    n_hi    = '0;
                    n_lo    = i_mplier;
                    n_b     = i_mcand;
                    n_d     = i_divisor;
                    n_cnt   = '0;
                    n_state = MD_MUL;
                end
            end
            MD_MUL: begin
                // add multiplicand into the high half, shift product right
                alu_a   = {1'b0, r_hi};
                alu_b   = r_lo[0] ? {1'b0, r_b} : '0;
                alu_sub = 1'b0;
                n_hi    = {alu_res[DATA_W], alu_res[DATA_W-1:1]};
                n_lo    = {alu_res[0], r_lo[DATA_W-1:1]};
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_state = MD_DIV;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            MD_DIV: begin
                // trial subtract; carry out set means no borrow
                alu_a   = {r_rem, r_hi[DATA_W-1]};
                alu_b   = {1'b0, r_d};
                alu_sub = 1'b1;
                n_rem   = alu_res[DATA_W+1] ? alu_res[DATA_W-1:0] : alu_a[DATA_W-1:0];
                n_hi    = {r_hi[DATA_W-2:0], r_lo[DATA_W-1]};
                n_lo    = {r_lo[DATA_W-2:0], alu_res[DATA_W+1]};
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = MD_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            MD_DONE: begin
                o_done  = 1'b1;
                n_state = MD_IDLE;
            end
            default: begin
                n_state = MD_IDLE;
            end
        endcase
    end

    assign o_quot = {r_hi, r_lo};

endmodule

`default_nettype wire

// ===== rtl/core/sample_hold_linear_extrapolator.sv =====
`default_nettype none

// One result transaction per input transaction. A reading whose sequence number differs
// from the previous one (reset value zero) is passed through as fresh and kept as the
// newest of two samples; otherwise the mode register selects hold, linear extrapolation
// from the two kept samples (hold while they are fewer than two or share a time), or no
// estimate. Fresh, held and no-estimate results load the result register at the edge
// that accepts the transaction. An extrapolated result is loaded once the shared
// bit-serial multiply/divide unit has been launched and has run 32 multiply steps and
// 64 divide steps; the input is not ready during that time. The input is ready
// whenever no extrapolation is running and the result register is empty or being
// drained in the same cycle. Write the mode register only while the block is idle.
module sample_hold_linear_extrapolator
    import shl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    shl_in_if.sink          i_in,
    shl_out_if.source       o_out,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata
);

    // configuration and tracking state
    logic [1:0]          r_mode;
    logic [DATA_W-1:0]   r_last_seq;
    logic [FILL_W-1:0]   r_fill;
    t_state              r_state, n_state;

    // kept samples: 1 is the newest, 0 the one before; unwritten entries are never read
    logic [DATA_W-1:0]   r_t0, r_t1;
    logic [DATA_W-1:0]   r_v0, r_v1;

    // extrapolation context held while the divider runs
    logic [DATA_W-1:0]   r_x_time, r_x_rms;
    logic                r_x_neg;
    logic [DATA_W-1:0]   r_adv, r_ael, r_adt;

    // result register
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_time, n_out_time;
    logic [DATA_W-1:0]   r_out_value, n_out_value;
    logic [DATA_W-1:0]   r_out_rms, n_out_rms;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    t_kind               r_out_kind, n_out_kind;

    logic                accept;
    logic                fresh;
    logic                start_calc;
    logic                r_calc_busy;
    logic                md_done;
    logic [2*DATA_W-1:0] md_quot;

    // magnitude/sign of the three differences, each as a subtract pair and a select
    logic [DATA_W:0]     dv_p, dv_n, dt_p, dt_n, el_p, el_n;
    logic [DATA_W-1:0]   adv, adt, ael;
    logic                neg;

    // final add and saturation
    logic                q_big;
    logic [DATA_W+1:0]   q_clamp;
    logic [DATA_W+3:0]   sum_ext;
    logic [DATA_W-1:0]   sat_value;

    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;
    assign fresh      = (i_in.seq_number != r_last_seq);

    assign dv_p = {r_v1[DATA_W-1], r_v1} - {r_v0[DATA_W-1], r_v0};
    assign dv_n = {r_v0[DATA_W-1], r_v0} - {r_v1[DATA_W-1], r_v1};
    assign dt_p = {1'b0, r_t1} - {1'b0, r_t0};
    assign dt_n = {1'b0, r_t0} - {1'b0, r_t1};
    assign el_p = {1'b0, i_in.now_time} - {1'b0, r_t1};
    assign el_n = {1'b0, r_t1} - {1'b0, i_in.now_time};
    assign adv  = dv_p[DATA_W] ? dv_n[DATA_W-1:0] : dv_p[DATA_W-1:0];
    assign adt  = dt_p[DATA_W] ? dt_n[DATA_W-1:0] : dt_p[DATA_W-1:0];
    assign ael  = el_p[DATA_W] ? el_n[DATA_W-1:0] : el_p[DATA_W-1:0];
    assign neg  = dv_p[DATA_W] ^ dt_p[DATA_W] ^ el_p[DATA_W];

    // clamp the increment to 2^33, then add or subtract and saturate to 32 bits
    assign q_big   = (|md_quot[2*DATA_W-1:DATA_W+2])
                   || (md_quot[DATA_W+1] && (|md_quot[DATA_W:0]));
    assign q_clamp = q_big ? {1'b1, {(DATA_W+1){1'b0}}} : md_quot[DATA_W+1:0];
    assign sum_ext = r_x_neg
                   ? ({{4{r_v1[DATA_W-1]}}, r_v1} - {2'b00, q_clamp})
                   : ({{4{r_v1[DATA_W-1]}}, r_v1} + {2'b00, q_clamp});

    always_comb begin
        if (sum_ext[DATA_W+3:DATA_W-1] == '0 || sum_ext[DATA_W+3:DATA_W-1] == '1) begin
            sat_value = sum_ext[DATA_W-1:0];
        end else if (sum_ext[DATA_W+3]) begin
            sat_value = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_value = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    shl_muldiv u_muldiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start_calc),
        .i_mcand   (r_adv),
        .i_mplier  (r_ael),
        .i_divisor (r_adt),
        .o_done    (md_done),
        .o_quot    (md_quot)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // mode register, last sequence number and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_NONE;
            r_last_seq <= '0;
            r_fill     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (accept) begin
                r_last_seq <= i_in.seq_number;
                if (fresh && (r_fill < FILL_W'(HISTORY_LENGTH))) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept && fresh) begin
            r_t0 <= r_t1;
            r_v0 <= r_v1;
            r_t1 <= i_in.now_time;
            r_v1 <= i_in.sample_value;
        end
        if (accept) begin
            r_x_time <= i_in.now_time;
            r_x_rms  <= i_in.sample_rms;
            r_x_neg  <= neg;
            r_adv    <= adv;
            r_adt    <= adt;
            r_ael    <= ael;
        end
        r_out_time   <= n_out_time;
        r_out_value  <= n_out_value;
        r_out_rms    <= n_out_rms;
        r_out_status <= n_out_status;
        r_out_kind   <= n_out_kind;
    end

    // next state and result selection
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_time   = r_out_time;
        n_out_value  = r_out_value;
        n_out_rms    = r_out_rms;
        n_out_status = r_out_status;
        n_out_kind   = r_out_kind;
        start_calc   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out_time   = i_in.now_time;
                    n_out_rms    = i_in.sample_rms;
                    n_out_status = '0;
                    n_out_value  = i_in.sample_value;
                    n_out_valid  = 1'b1;
                    if (fresh) begin
                        n_out_status = i_in.sample_status;
                        n_out_kind   = KIND_FRESH;
                    end else begin
                        case (r_mode)
                            MODE_HOLD: begin
                                n_out_kind = KIND_HELD;
                            end
                            MODE_EXTRAP: begin
                                if ((r_fill < FILL_W'(HISTORY_LENGTH)) || (r_t1 == r_t0)) begin
                                    n_out_kind = KIND_HELD;
                                end else begin
                                    // hold the result back until the divider finishes
                                    n_out_valid = 1'b0;
                                    n_state     = ST_CALC;
                                end
                            end
                            default: begin
                                n_out_value = '0;
                                n_out_kind  = KIND_NONE;
                            end
                        endcase
                    end
                end
            end
            ST_CALC: begin
                start_calc = (r_state == ST_CALC) && !md_done && !r_calc_busy;
                if (md_done) begin
                    n_out_time   = r_x_time;
                    n_out_rms    = r_x_rms;
                    n_out_status = '0;
                    n_out_value  = sat_value;
                    n_out_kind   = KIND_EXTRAP;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // launch the shared unit once per extrapolation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calc_busy <= 1'b0;
        end else if (md_done) begin
            r_calc_busy <= 1'b0;
        end else if (start_calc) begin
            r_calc_busy <= 1'b1;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.valid_time  = r_out_time;
    assign o_out.out_value   = r_out_value;
    assign o_out.out_rms     = r_out_rms;
    assign o_out.out_status  = r_out_status;
    assign o_out.result_kind = r_out_kind;

endmodule

`default_nettype wire
